// ===== design/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgr_pkg: shared types and constants for the stable rotation engine
// Holds the per-stage payload carried down the cell chain.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int unsigned NumCells = 32;
  localparam logic [31:0] OneQ30  = 32'h4000_0000;

  typedef struct packed {
    logic         valid;
    logic         a_neg;
    logic         b_neg;
    logic         zero;
    logic [63:0]  s;
    logic [31:0]  q;
    logic [63:0]  rem;
    logic [127:0] ea;
    logic [95:0]  pa;
    logic [31:0]  fa;
    logic [127:0] eb;
    logic [95:0]  pb;
    logic [31:0]  fb;
  } sgr_cell_t;

endpackage

// ===== design/stable_givens_rotation.sv =====
// ----------------------------------------------------------------------------
// stable_givens_rotation: fixed-point rotation parameters c, s and norm r
// Pipelined chain of 32 bit cells computing sqrt and both ratios.
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  s_axis   in   a_value, b_value (signed Q16.16)
//  m_axis   out  cosine, sine (signed Q2.30), norm (unsigned Q16.16)
//
//  one transaction per cycle while the output is not stalled; 2 front stages,
//  32 bit cells and 1 output register
//  rst clears all valid bits; payload registers are not reset
//  a stalled output freezes the whole pipeline until m_tready
// ----------------------------------------------------------------------------
module stable_givens_rotation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // a_value [31:0], b_value [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata    // cosine [31:0], sine [63:32], norm [95:64]
);
  import sgr_pkg::*;

  logic      en;
  sgr_cell_t chain [NumCells+1];
  logic [31:0] mag_c, mag_s, root;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  sgr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .a_value  (s_tdata[31:0]),
    .b_value  (s_tdata[63:32]),
    .cout     (chain[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    sgr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .bit_idx (5'(NumCells - 1 - k)),
      .cin     (chain[k]),
      .cout    (chain[k+1])
    );
  end

  always_comb begin
    mag_c = 32'(({1'b0, chain[NumCells].fa} + 33'd1) >> 1);
    mag_s = 32'(({1'b0, chain[NumCells].fb} + 33'd1) >> 1);
    // round to nearest: remainder above q means past the midpoint
    root  = ({32'd0, chain[NumCells].q} < chain[NumCells].rem) ?
            chain[NumCells].q + 32'd1 : chain[NumCells].q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= chain[NumCells].valid;
      if (chain[NumCells].zero) begin
        m_tdata <= {32'd0, 32'd0, OneQ30};
      end else begin
        m_tdata[31:0]  <= chain[NumCells].a_neg ? (~mag_c + 32'd1) : mag_c;
        m_tdata[63:32] <= chain[NumCells].b_neg ? (~mag_s + 32'd1) : mag_s;
        m_tdata[95:64] <= root;
      end
    end
  end

`ifndef ASSERT_OFF
  a_zero_norm : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[95:64] == 32'd0) |-> (m_tdata[31:0] == OneQ30) && (m_tdata[63:32] == 32'd0))
    else $error("zero norm without unit cosine");
  a_cos_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(OneQ30)) &&
                 ($signed(m_tdata[31:0]) >= -$signed(OneQ30)))
    else $error("cosine out of range");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled transaction not held");
`endif

endmodule

// ===== design/sgr_cell.sv =====
// ----------------------------------------------------------------------------
// sgr_cell: one bit of the root and ratio recurrences
// Decides one result bit of sqrt(s) and of both scaled ratios per cycle while en is high.
// ----------------------------------------------------------------------------
module sgr_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [4:0]        bit_idx,
  input  sgr_pkg::sgr_cell_t cin,
  output sgr_pkg::sgr_cell_t cout
);
  import sgr_pkg::*;

  sgr_cell_t   nxt;
  logic [65:0] trial;
  logic [129:0] da;
  logic [129:0] db;

  always_comb begin
    nxt   = cin;
    // (q + 2^i)^2 - q^2
    trial = ({34'd0, cin.q} << ({1'b0, bit_idx} + 6'd1)) + (66'd1 << ({1'b0, bit_idx} << 1));
    if ({2'b00, cin.rem} >= trial) begin
      nxt.rem = cin.rem - trial[63:0];
      nxt.q   = cin.q | (32'd1 << bit_idx);
    end
    // (f + 2^i)^2 * s - f^2 * s, with p = f * s
    da = ({34'd0, cin.pa} << ({1'b0, bit_idx} + 6'd1)) + ({66'd0, cin.s} << ({1'b0, bit_idx} << 1));
    if ({2'b00, cin.ea} >= da) begin
      nxt.ea = cin.ea - da[127:0];
      nxt.pa = cin.pa + ({32'd0, cin.s} << bit_idx);
      nxt.fa = cin.fa | (32'd1 << bit_idx);
    end
    db = ({34'd0, cin.pb} << ({1'b0, bit_idx} + 6'd1)) + ({66'd0, cin.s} << ({1'b0, bit_idx} << 1));
    if ({2'b00, cin.eb} >= db) begin
      nxt.eb = cin.eb - db[127:0];
      nxt.pb = cin.pb + ({32'd0, cin.s} << bit_idx);
      nxt.fb = cin.fb | (32'd1 << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (en) begin
      cout <= nxt;
    end
  end

endmodule

// ===== design/sgr_front.sv =====
// ----------------------------------------------------------------------------
// sgr_front: magnitudes and squares
// Two stages: take magnitudes, then square; builds the chain's first payload.
// ----------------------------------------------------------------------------
module sgr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       a_value,
  input  logic [31:0]       b_value,
  output sgr_pkg::sgr_cell_t cout
);
  import sgr_pkg::*;

  logic        v1, v2;
  logic        an1, bn1, an2, bn2;
  logic [31:0] am, bm;
  logic [63:0] sqa, sqb;
  logic [63:0] s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      an1 <= a_value[31];
      bn1 <= b_value[31];
      am  <= a_value[31] ? (~a_value + 32'd1) : a_value;
      bm  <= b_value[31] ? (~b_value + 32'd1) : b_value;
      v2  <= v1;
      an2 <= an1;
      bn2 <= bn1;
      sqa <= 64'(am) * 64'(am);
      sqb <= 64'(bm) * 64'(bm);
    end
  end

  always_comb begin
    s          = sqa + sqb;
    cout.valid = v2;
    cout.a_neg = an2;
    cout.b_neg = bn2;
    cout.zero  = (s == 64'd0);
    cout.s     = s;
    cout.q     = 32'd0;
    cout.rem   = s;
    cout.ea    = {2'b00, sqa, 62'd0};
    cout.pa    = 96'd0;
    cout.fa    = 32'd0;
    cout.eb    = {2'b00, sqb, 62'd0};
    cout.pb    = 96'd0;
    cout.fb    = 32'd0;
  end

endmodule
